// ----- hw/rtl/ira_pkg.sv -----
// Package for the radix ASCII converter: sizes, codes, radix limits, states, digit_char.
`default_nettype none
package ira_pkg;

    localparam int MAX_DIGITS  = 64;
    localparam int VALUE_WIDTH = 64;

    localparam int ADDR_W = $clog2(MAX_DIGITS);
    localparam int CNT_W  = $clog2(MAX_DIGITS + 1);
    localparam int BIT_W  = $clog2(VALUE_WIDTH);

    localparam logic [7:0] CH_ZERO  = 8'h30;  // '0'
    localparam logic [7:0] CH_UPPER = 8'h41;  // 'A'
    localparam logic [7:0] CH_LOWER = 8'h61;  // 'a'
    localparam logic [7:0] CH_MINUS = 8'h2D;  // '-'

    localparam logic [5:0] RADIX_MIN = 6'd2;
    localparam logic [5:0] RADIX_MAX = 6'd36;
    localparam logic [5:0] RADIX_DEC = 6'd10;

    localparam logic [1:0] ACT_S32 = 2'd0;
    localparam logic [1:0] ACT_S64 = 2'd1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_SIGN,
        ST_RD,
        ST_OUT
    } t_state;

    function automatic logic [7:0] digit_char(input logic [5:0] d, input logic lower);
        logic [7:0] base;
        base = lower ? CH_LOWER : CH_UPPER;
        if (d < 6'd10) begin
            return CH_ZERO + {2'b00, d};
        end
        return base + {2'b00, d} - 8'd10;
    endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/integer_to_radix_ascii_top.sv -----
// Top level of the integer to radix ASCII converter: bit-serial divider, digit store, emitter.
//
// Input channel (i_in_valid / o_in_ready) takes one number: i_action selects
// signed 32-bit, signed 64-bit (magnitude only) or unsigned interpretation of i_value,
// i_radix the base (clamped to 2..36), i_lower_case the letter case (unsigned
// only). Output channel (o_out_valid / i_out_ready) gives one ASCII character
// per transfer, most significant first, o_last_char set on the final one;
// base-10 negative numbers in signed 32-bit mode get a leading '-'.
// Each digit comes from a restoring divider over the whole value that shifts
// one quotient bit per cycle; digits go least significant first into a
// MAX_DIGITS x 6 memory. Each digit character then takes a registered memory read,
// then a load of the output register, which waits while the receiver stalls.
// One number is handled at a time; o_in_ready rises again once the last
// character sits in the output register, so the next number may be taken
// while that character still waits for the receiver.
// A stalled receiver holds the output register and stops emission; nothing is
// dropped. Synchronous reset returns to idle with no output pending; the digit
// memory is not cleared, as every entry is written before it is read.
`default_nettype none
module integer_to_radix_ascii_top (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_ready,
    input  wire logic [1:0] i_action,
    input  wire logic [63:0] i_value,
    input  wire logic [5:0] i_radix,
    input  wire logic       i_lower_case,
    output logic            o_out_valid,
    input  wire logic       i_out_ready,
    output logic [7:0]      o_char_code,
    output logic            o_last_char
);
    import ira_pkg::*;

    t_state                   r_state, n_state;
    logic [VALUE_WIDTH-1:0]   r_quo,   n_quo;      // quotient shift register
    logic [5:0]               r_rem,   n_rem;      // partial remainder
    logic [BIT_W-1:0]         r_bit,   n_bit;      // index of the current bit, counting down
    logic                     r_qnz,   n_qnz;      // quotient nonzero so far
    logic [CNT_W-1:0]         r_cnt,   n_cnt;      // digits stored / left to emit
    logic [5:0]               r_radix, n_radix;
    logic                     r_lower, n_lower;
    logic                     r_minus, n_minus;
    logic                     r_ovld,  n_ovld;
    logic [7:0]               r_char,  n_char;
    logic                     r_last,  n_last;

    logic [5:0]               mem [MAX_DIGITS];
    logic [5:0]               r_rd;
    logic                     mem_we;

    // Input decode
    logic [5:0]               rad_c;
    logic [VALUE_WIDTH-1:0]   val_m;
    logic [31:0]              lo_neg;
    logic [VALUE_WIDTH-1:0]   mag_c;
    logic                     minus_c;
    logic                     lower_c;

    // Divider step
    logic [6:0]               trial;
    logic                     ge;
    logic [5:0]               rem_step;
    logic                     qnz_step;
    logic [CNT_W-1:0]         cnt_inc;
    logic [CNT_W-1:0]         room;
    logic                     out_free;

    always_comb begin
        priority if (i_radix < RADIX_MIN) begin
            rad_c = RADIX_MIN;
        end else if (i_radix > RADIX_MAX) begin
            rad_c = RADIX_MAX;
        end else begin
            rad_c = i_radix;
        end

        val_m   = i_value[VALUE_WIDTH-1:0];
        lo_neg  = 32'd0 - val_m[31:0];
        minus_c = 1'b0;
        lower_c = 1'b0;
        unique case (i_action)
            ACT_S32: begin
                if (val_m[31]) begin
                    mag_c   = VALUE_WIDTH'(lo_neg);
                    minus_c = (rad_c == RADIX_DEC);
                end else begin
                    mag_c = VALUE_WIDTH'(val_m[31:0]);
                end
            end
            ACT_S64: begin
                mag_c = val_m[VALUE_WIDTH-1] ? ({VALUE_WIDTH{1'b0}} - val_m) : val_m;
            end
            default: begin
                mag_c   = val_m;
                lower_c = i_lower_case;
            end
        endcase
    end

    // Restoring division, one quotient bit per cycle
    assign trial    = {r_rem, r_quo[VALUE_WIDTH-1]};
    assign ge       = (trial >= {1'b0, r_radix});
    assign rem_step = ge ? 6'(trial - {1'b0, r_radix}) : trial[5:0];
    assign qnz_step = r_qnz | ge;
    assign cnt_inc  = r_cnt + CNT_W'(1);
    assign room     = r_minus ? CNT_W'(MAX_DIGITS - 1) : CNT_W'(MAX_DIGITS);
    assign out_free = !r_ovld || i_out_ready;

    assign o_in_ready = (r_state == ST_IDLE);
    assign mem_we     = (r_state == ST_DIV) && (r_bit == '0);

    always_comb begin
        n_state = r_state;
        n_quo   = r_quo;
        n_rem   = r_rem;
        n_bit   = r_bit;
        n_qnz   = r_qnz;
        n_cnt   = r_cnt;
        n_radix = r_radix;
        n_lower = r_lower;
        n_minus = r_minus;
        n_ovld  = r_ovld && !i_out_ready;
        n_char  = r_char;
        n_last  = r_last;

        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_quo   = mag_c;
                    n_rem   = '0;
                    n_bit   = BIT_W'(VALUE_WIDTH - 1);
                    n_qnz   = 1'b0;
                    n_cnt   = '0;
                    n_radix = rad_c;
                    n_lower = lower_c;
                    n_minus = minus_c;
                    n_state = ST_DIV;
                end
            end
            ST_DIV: begin
                n_quo = {r_quo[VALUE_WIDTH-2:0], ge};
                n_rem = rem_step;
                n_qnz = qnz_step;
                n_bit = r_bit - BIT_W'(1);
                if (r_bit == '0) begin
                    // digit done: stored this cycle, start the next or go emit
                    n_cnt = cnt_inc;
                    n_rem = '0;
                    n_qnz = 1'b0;
                    n_bit = BIT_W'(VALUE_WIDTH - 1);
                    if (!(qnz_step && (cnt_inc < room))) begin
                        n_state = r_minus ? ST_SIGN : ST_RD;
                    end
                end
            end
            ST_SIGN: begin
                if (out_free) begin
                    n_ovld  = 1'b1;
                    n_char  = CH_MINUS;
                    n_last  = 1'b0;
                    n_state = ST_RD;
                end
            end
            ST_RD: begin
                n_cnt   = r_cnt - CNT_W'(1);
                n_state = ST_OUT;
            end
            ST_OUT: begin
                if (out_free) begin
                    n_ovld  = 1'b1;
                    n_char  = digit_char(r_rd, r_lower);
                    n_last  = (r_cnt == '0);
                    n_state = (r_cnt == '0) ? ST_IDLE : ST_RD;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_ovld  <= 1'b0;
            r_cnt   <= '0;
            r_bit   <= '0;
            r_qnz   <= 1'b0;
            r_minus <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ovld  <= n_ovld;
            r_cnt   <= n_cnt;
            r_bit   <= n_bit;
            r_qnz   <= n_qnz;
            r_minus <= n_minus;
        end
    end

    always_ff @(posedge i_clk) begin
        r_quo   <= n_quo;
        r_rem   <= n_rem;
        r_radix <= n_radix;
        r_lower <= n_lower;
        r_char  <= n_char;
        r_last  <= n_last;
    end

    // Digit memory: write while dividing, registered read during emission;
    // hold the read digit while the output stalls
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[r_cnt[ADDR_W-1:0]] <= rem_step;
        end
        if (r_state == ST_RD) begin
            r_rd <= mem[ADDR_W'(r_cnt - CNT_W'(1))];
        end
    end

    assign o_out_valid = r_ovld;
    assign o_char_code = r_char;
    assign o_last_char = r_last;

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV) |-> (r_cnt < CNT_W'(MAX_DIGITS)))
        else $error("digit count past memory depth");

    a_start_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (r_state == ST_DIV && r_cnt == '0))
        else $error("transfer did not start division");

    a_rd_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RD) |-> (r_cnt != '0))
        else $error("read with no stored digit");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovld && !i_out_ready) |=> (r_ovld && $stable(r_char) && $stable(r_last)))
        else $error("output register changed under stall");

endmodule
`default_nettype wire
